// ===== design/aprm_pkg.sv =====
// Shared types and constants for the anemometer pulse rate meter.
// No dependencies; imported by every module of the block.

package aprm_pkg;

    localparam int NUM_W    = 55;
    localparam int PROD_W   = 39;
    localparam int HI_W     = NUM_W - 32;
    localparam int COUNT_W  = 15;
    localparam int PEND_W   = 14;
    localparam int SPEED_W  = 24;

    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    localparam logic [2:0] REG_TICK_RATE   = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE    = 3'd1;
    localparam logic [2:0] REG_MIN_WINDOW  = 3'd2;
    localparam logic [2:0] REG_MAX_WINDOW  = 3'd3;
    localparam logic [2:0] REG_KNOTS       = 3'd4;
    localparam logic [2:0] REG_PEND_LIMIT  = 3'd5;

    localparam logic [15:0] TICK_RATE_RST  = 16'd1000;
    localparam logic [15:0] DEBOUNCE_RST   = 16'd5;
    localparam logic [15:0] MIN_WINDOW_RST = 16'd400;
    localparam logic [15:0] MAX_WINDOW_RST = 16'd3000;
    localparam logic [23:0] KNOTS_RST      = 24'd84969;
    localparam logic [13:0] PEND_LIMIT_RST = 14'd10000;

    typedef struct packed {
        logic               valid;
        logic               timed_out;
        logic [COUNT_W-1:0] count;
    } report_t;

endpackage

// ===== design/aprm_win.sv =====
// Tick counter, edge debounce, pending pulse counter and window sequencer.
// Depends on aprm_pkg; raises one report request per closed window.

module aprm_win import aprm_pkg::*; #(
    parameter int TICK_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick_accept,
    input  logic                  edge_seen,
    input  logic [15:0]           debounce_ticks,
    input  logic [15:0]           min_window_ticks,
    input  logic [15:0]           max_window_ticks,
    input  logic [PEND_W-1:0]     pending_limit,
    output report_t               report,
    output logic [TICK_WIDTH-1:0] report_elapsed
);

    localparam logic PH_MIN   = 1'b0;
    localparam logic PH_EXTRA = 1'b1;

    logic [TICK_WIDTH-1:0] tick_reg, tick_next;
    logic [TICK_WIDTH-1:0] last_edge_reg, last_edge_next;
    logic [TICK_WIDTH-1:0] ref_tick_reg, ref_tick_next;
    logic [PEND_W-1:0]     pend_reg, pend_next;
    logic                  phase_reg, phase_next;
    logic [15:0]           timer_reg, timer_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [15:0]           extra;
    logic                  rep_valid;
    logic                  got_extra;
    logic                  timed_out;

    assign extra = (max_window_ticks > min_window_ticks) ?
                   max_window_ticks - min_window_ticks : 16'd0;

    always_comb begin
        tick_next      = tick_reg;
        last_edge_next = last_edge_reg;
        ref_tick_next  = ref_tick_reg;
        pend_next      = pend_reg;
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        count_next     = count_reg;
        rep_valid      = 1'b0;
        got_extra      = 1'b0;
        timed_out      = 1'b0;
        if (tick_accept) begin
            if (edge_seen) begin
                if ((tick_reg - last_edge_reg) > TICK_WIDTH'(debounce_ticks) &&
                    pend_reg < pending_limit) begin
                    pend_next = pend_reg + 1'b1;
                end
                last_edge_next = tick_reg;
            end
            timer_next = (timer_reg != 16'hFFFF) ? timer_reg + 16'd1 : timer_reg;
            if (phase_reg == PH_MIN) begin
                if (timer_next >= min_window_ticks) begin
                    count_next = COUNT_W'(1) + COUNT_W'(pend_next);
                    pend_next  = '0;
                    phase_next = PH_EXTRA;
                    timer_next = '0;
                    if (extra == 16'd0) begin
                        rep_valid = 1'b1;
                    end
                end
            end else begin
                if (pend_next != '0) begin
                    pend_next = pend_next - 1'b1;
                    rep_valid = 1'b1;
                    got_extra = 1'b1;
                end else if (timer_next >= extra) begin
                    rep_valid = 1'b1;
                end
            end
            timed_out = !(got_extra || count_next > COUNT_W'(1));
            if (rep_valid) begin
                if (!timed_out) begin
                    ref_tick_next = tick_reg;
                end
                phase_next = PH_MIN;
                timer_next = '0;
            end
            tick_next = tick_reg + 1'b1;
        end
    end

    assign report.valid     = rep_valid;
    assign report.timed_out = timed_out;
    assign report.count     = count_next;
    assign report_elapsed   = tick_reg - ref_tick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            last_edge_reg <= '0;
            ref_tick_reg  <= '0;
            pend_reg      <= '0;
            phase_reg     <= PH_MIN;
            timer_reg     <= '0;
            count_reg     <= '0;
        end else begin
            tick_reg      <= tick_next;
            last_edge_reg <= last_edge_next;
            ref_tick_reg  <= ref_tick_next;
            pend_reg      <= pend_next;
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            count_reg     <= count_next;
        end
    end

endmodule

// ===== design/aprm_arith.sv =====
// Speed unit: two registered multiplies, then a shared compare/subtract
// stepped 32 times as a restoring divider. Depends on aprm_pkg.

module aprm_arith import aprm_pkg::*; #(
    parameter int TICK_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [23:0]           knots_per_pulse_q16,
    input  logic [15:0]           tick_rate_hz,
    input  logic [COUNT_W-1:0]    count,
    input  logic [TICK_WIDTH-1:0] elapsed,
    output logic                  done,
    output logic [SPEED_W-1:0]    speed
);

    localparam int OPW = (TICK_WIDTH + 1 > HI_W + 1) ? TICK_WIDTH + 1 : HI_W + 1;

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL1 = 3'd1;
    localparam logic [2:0] A_MUL2 = 3'd2;
    localparam logic [2:0] A_CHK  = 3'd3;
    localparam logic [2:0] A_DIV  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [TICK_WIDTH-1:0] div_reg, div_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [TICK_WIDTH-1:0] rem_reg, rem_next;
    logic [31:0]           sh_reg, sh_next;
    logic [4:0]            step_reg, step_next;
    logic                  done_reg, done_next;
    logic [SPEED_W-1:0]    speed_reg, speed_next;
    logic [OPW-1:0]        opa;
    logic [OPW-1:0]        diff;
    logic                  ge;

    always_comb begin
        if (state_reg == A_CHK) begin
            opa = OPW'(num_reg[NUM_W-1:32]);
        end else begin
            opa = OPW'({rem_reg, sh_reg[31]});
        end
        ge   = opa >= OPW'(div_reg);
        diff = opa - OPW'(div_reg);
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        div_next   = div_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        speed_next = speed_reg;
        case (state_reg)
            A_IDLE: begin
                if (start) begin
                    count_next = count;
                    div_next   = elapsed;
                    if (elapsed == '0) begin
                        speed_next = SPEED_MAX;
                        done_next  = 1'b1;
                    end else begin
                        state_next = A_MUL1;
                    end
                end
            end
            A_MUL1: begin
                prod_next  = PROD_W'(knots_per_pulse_q16) * PROD_W'(count_reg);
                state_next = A_MUL2;
            end
            A_MUL2: begin
                num_next   = NUM_W'(prod_reg) * NUM_W'(tick_rate_hz);
                state_next = A_CHK;
            end
            A_CHK: begin
                if (ge) begin
                    speed_next = SPEED_MAX;
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end else begin
                    rem_next   = TICK_WIDTH'(opa);
                    sh_next    = num_reg[31:0];
                    step_next  = '0;
                    state_next = A_DIV;
                end
            end
            A_DIV: begin
                rem_next  = ge ? TICK_WIDTH'(diff) : TICK_WIDTH'(opa);
                sh_next   = {sh_reg[30:0], ge};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31) begin
                    speed_next = sh_next[31:8];
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
        count_reg <= count_next;
        div_reg   <= div_next;
        prod_reg  <= prod_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        sh_reg    <= sh_next;
        speed_reg <= speed_next;
    end

    assign done  = done_reg;
    assign speed = speed_reg;

endmodule

// ===== design/anemometer_pulse_rate_meter.sv =====
// Anemometer pulse rate meter: one tick beat in, at most one report beat out.
// Ticks that close no window keep s_tready high and may follow back to back.
// A timed-out report passes ST_HOLD into the output register; a speed report
// waits in ST_CALC on two multiplies, one range check and 32 divider steps.
// Synchronous active-low reset clears all window state and loads the
// register defaults. Depends on aprm_pkg, aprm_win and aprm_arith.

module anemometer_pulse_rate_meter import aprm_pkg::*; #(
    parameter int TICK_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] edge_seen, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [23:0] speed_q8, [38:24] pulse_count,
                                   // [70:39] elapsed_ticks, [71] zero
    output logic [0:0]  m_tuser,   // [0] timed_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [15:0]        rate_reg;
    logic [15:0]        debounce_reg;
    logic [15:0]        min_win_reg;
    logic [15:0]        max_win_reg;
    logic [23:0]        knots_reg;
    logic [PEND_W-1:0]  limit_reg;
    logic [2:0]         reg_index;
    logic               cfg_write;

    logic [1:0]         state_reg, state_next;
    logic               tick_accept;
    report_t            report;
    logic [TICK_WIDTH-1:0] report_elapsed;
    logic [31:0]        elapsed_sat;
    logic               arith_start;
    logic               arith_done;
    logic [SPEED_W-1:0] arith_speed;

    logic [SPEED_W-1:0] res_speed_reg, res_speed_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;
    logic [31:0]        res_elapsed_reg, res_elapsed_next;
    logic               res_timeout_reg, res_timeout_next;

    logic               m_valid_reg, m_valid_next;
    logic [SPEED_W-1:0] m_speed_reg, m_speed_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic [31:0]        m_elapsed_reg, m_elapsed_next;
    logic               m_timeout_reg, m_timeout_next;

    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg     <= TICK_RATE_RST;
            debounce_reg <= DEBOUNCE_RST;
            min_win_reg  <= MIN_WINDOW_RST;
            max_win_reg  <= MAX_WINDOW_RST;
            knots_reg    <= KNOTS_RST;
            limit_reg    <= PEND_LIMIT_RST;
        end else if (cfg_write) begin
            case (reg_index)
                REG_TICK_RATE:  rate_reg     <= pwdata[15:0];
                REG_DEBOUNCE:   debounce_reg <= pwdata[15:0];
                REG_MIN_WINDOW: min_win_reg  <= pwdata[15:0];
                REG_MAX_WINDOW: max_win_reg  <= pwdata[15:0];
                REG_KNOTS:      knots_reg    <= pwdata[23:0];
                REG_PEND_LIMIT: limit_reg    <= pwdata[PEND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_TICK_RATE:  prdata = 32'(rate_reg);
            REG_DEBOUNCE:   prdata = 32'(debounce_reg);
            REG_MIN_WINDOW: prdata = 32'(min_win_reg);
            REG_MAX_WINDOW: prdata = 32'(max_win_reg);
            REG_KNOTS:      prdata = 32'(knots_reg);
            REG_PEND_LIMIT: prdata = 32'(limit_reg);
            default:        prdata = '0;
        endcase
    end

    assign s_tready    = (state_reg == ST_IDLE);
    assign tick_accept = s_tvalid && s_tready;
    assign arith_start = tick_accept && report.valid && !report.timed_out;
    assign elapsed_sat = (|(report_elapsed >> 32)) ? '1 : 32'(report_elapsed);

    aprm_win #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_win (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .tick_accept      (tick_accept),
        .edge_seen        (s_tdata[0]),
        .debounce_ticks   (debounce_reg),
        .min_window_ticks (min_win_reg),
        .max_window_ticks (max_win_reg),
        .pending_limit    (limit_reg),
        .report           (report),
        .report_elapsed   (report_elapsed)
    );

    aprm_arith #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_arith (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .start               (arith_start),
        .knots_per_pulse_q16 (knots_reg),
        .tick_rate_hz        (rate_reg),
        .count               (report.count),
        .elapsed             (report_elapsed),
        .done                (arith_done),
        .speed               (arith_speed)
    );

    always_comb begin
        state_next       = state_reg;
        res_speed_next   = res_speed_reg;
        res_count_next   = res_count_reg;
        res_elapsed_next = res_elapsed_reg;
        res_timeout_next = res_timeout_reg;
        m_valid_next     = m_valid_reg;
        m_speed_next     = m_speed_reg;
        m_count_next     = m_count_reg;
        m_elapsed_next   = m_elapsed_reg;
        m_timeout_next   = m_timeout_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (tick_accept && report.valid) begin
                    res_speed_next   = '0;
                    res_count_next   = report.count;
                    res_elapsed_next = elapsed_sat;
                    res_timeout_next = report.timed_out;
                    state_next       = report.timed_out ? ST_HOLD : ST_CALC;
                end
            end
            ST_CALC: begin
                if (arith_done) begin
                    res_speed_next = arith_speed;
                    state_next     = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_valid_next) begin
                    m_valid_next   = 1'b1;
                    m_speed_next   = res_speed_reg;
                    m_count_next   = res_count_reg;
                    m_elapsed_next = res_elapsed_reg;
                    m_timeout_next = res_timeout_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        res_speed_reg   <= res_speed_next;
        res_count_reg   <= res_count_next;
        res_elapsed_reg <= res_elapsed_next;
        res_timeout_reg <= res_timeout_next;
        m_speed_reg     <= m_speed_next;
        m_count_reg     <= m_count_next;
        m_elapsed_reg   <= m_elapsed_next;
        m_timeout_reg   <= m_timeout_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_elapsed_reg, m_count_reg, m_speed_reg};
    assign m_tuser  = m_timeout_reg;

endmodule

// ===== tb/sv/tb_anemometer_pulse_rate_meter.sv =====
// Self-checking testbench for anemometer_pulse_rate_meter: drives tick beats and
// register-port writes, predicts each wind report and checks every result beat in order.
// Depends on aprm_pkg and the anemometer_pulse_rate_meter RTL.

module tb_anemometer_pulse_rate_meter import aprm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_TICKS   = 1650;
    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTED   = 10;

    typedef struct packed {
        logic [23:0] speed_q8;
        logic [14:0] pulse_count;
        logic [31:0] elapsed_ticks;
        logic        timed_out;
    } wind_report_t;

    typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_CADENCE, RDY_MOSTLY} ready_mode_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [2:0]   reg_idx;
        logic [31:0]  value;
        logic         pulse;
        logic         pinned;
        wind_report_t want;
    } plan_row_t;

    localparam plan_row_t DIRECTED_PLAN [42] = '{
        '{ROW_CFG,  REG_MIN_WINDOW, 32'd2,        1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_MAX_WINDOW, 32'd2,        1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_DEBOUNCE,   32'd0,        1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b1, '{24'd0, 15'd1, 32'd1, 1'b1}},
        '{ROW_TICK, '0,             32'd0,        1'b1, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b1, 1'b0, '0},
        '{ROW_CFG,  REG_MAX_WINDOW, 32'd4,        1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_KNOTS,      32'hFF_FFFF,  1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_TICK_RATE,  32'd65535,    1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_PEND_LIMIT, 32'd16383,    1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b1, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b1, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b1, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_DEBOUNCE,   32'd65535,    1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b1, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b1, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_PEND_LIMIT, 32'd1,        1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_DEBOUNCE,   32'd0,        1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b1, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b1, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b1, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_KNOTS,      32'd0,        1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_TICK_RATE,  32'd1,        1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b1, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b1, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_MIN_WINDOW, 32'd65535,    1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_MAX_WINDOW, 32'd65535,    1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_MIN_WINDOW, 32'd1,        1'b0, 1'b0, '0},
        '{ROW_CFG,  REG_MAX_WINDOW, 32'd2,        1'b0, 1'b0, '0},
        '{ROW_TICK, '0,             32'd0,        1'b0, 1'b0, '0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [0] edge_seen, [7:1] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;          // [23:0] speed_q8, [38:24] pulse_count,
                                   // [70:39] elapsed_ticks, [71] zero
    logic [0:0]  m_tuser;          // [0] timed_out
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [15:0] rate_hz;
    logic [15:0] debounce;
    logic [15:0] min_win;
    logic [15:0] max_win;
    logic [23:0] knots_q16;
    logic [13:0] pend_limit;
    logic [31:0] tick_now;
    logic [31:0] last_pulse_tick;
    logic [31:0] ref_tick;
    logic [13:0] pending;
    logic        draining;
    logic [15:0] phase_timer;
    logic [14:0] win_count;

    wind_report_t awaited_reports[$];

    logic         beat_pinned = 1'b0;
    wind_report_t beat_want = '0;
    int           burst_left = 0;
    ready_mode_t  ready_mode = RDY_ALWAYS;
    int           ready_left = 0;

    int faults = 0;
    int idle_cycles = 0;
    int ticks_taken = 0;
    int reg_writes = 0;
    int reports_seen = 0;
    int timeouts_seen = 0;
    int saturated_seen = 0;

    anemometer_pulse_rate_meter dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic wind_report_t close_window(input logic [31:0] now,
                                                  input logic got_extra);
        wind_report_t r;
        logic [63:0]  num;
        logic [63:0]  quot;
        r.elapsed_ticks = now - ref_tick;
        r.pulse_count   = win_count;
        r.timed_out     = !(got_extra || win_count > 15'd1);
        r.speed_q8      = '0;
        if (!r.timed_out) begin
            if (r.elapsed_ticks == '0) begin
                r.speed_q8 = SPEED_MAX;
            end else begin
                num  = 64'(knots_q16) * 64'(win_count) * 64'(rate_hz);
                quot = (num / 64'(r.elapsed_ticks)) >> 8;
                r.speed_q8 = (quot > 64'(SPEED_MAX)) ? SPEED_MAX : quot[23:0];
            end
            ref_tick = now;
        end
        draining    = 1'b0;
        phase_timer = '0;
        return r;
    endfunction

    function automatic logic meter_tick(input logic pulse, output wind_report_t r);
        logic [31:0] now;
        logic [31:0] since_pulse;
        logic [15:0] extra;
        logic        fired;
        now   = tick_now;
        fired = 1'b0;
        r     = '0;
        if (pulse) begin
            since_pulse = now - last_pulse_tick;
            if (since_pulse > 32'(debounce) && pending < pend_limit)
                pending = pending + 14'd1;
            last_pulse_tick = now;
        end
        extra = (max_win > min_win) ? max_win - min_win : 16'd0;
        if (phase_timer != 16'hFFFF)
            phase_timer = phase_timer + 16'd1;
        if (!draining) begin
            if (phase_timer >= min_win) begin
                win_count   = 15'(pending) + 15'd1;
                pending     = '0;
                draining    = 1'b1;
                phase_timer = '0;
                if (extra == 16'd0) begin
                    r     = close_window(now, 1'b0);
                    fired = 1'b1;
                end
            end
        end else if (pending != '0) begin
            pending = pending - 14'd1;
            r       = close_window(now, 1'b1);
            fired   = 1'b1;
        end else if (phase_timer >= extra) begin
            r     = close_window(now, 1'b0);
            fired = 1'b1;
        end
        tick_now = now + 32'd1;
        return fired;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_TICK_RATE:  rate_hz    = val[15:0];
            REG_DEBOUNCE:   debounce   = val[15:0];
            REG_MIN_WINDOW: min_win    = val[15:0];
            REG_MAX_WINDOW: max_win    = val[15:0];
            REG_KNOTS:      knots_q16  = val[23:0];
            REG_PEND_LIMIT: pend_limit = val[13:0];
            default: ;
        endcase
    endfunction

    function automatic void log_fault(input string what, input wind_report_t want,
                                      input wind_report_t seen);
        faults++;
        if (faults <= MAX_REPORTED)
            $display("%0t %s: expected speed=%0d count=%0d elapsed=%0d timed_out=%0d,",
                     $time, what, want.speed_q8, want.pulse_count, want.elapsed_ticks,
                     want.timed_out, " got speed=%0d count=%0d elapsed=%0d timed_out=%0d",
                     seen.speed_q8, seen.pulse_count, seen.elapsed_ticks, seen.timed_out);
    endfunction

    always @(posedge aclk) begin
        wind_report_t predicted;
        wind_report_t seen;
        wind_report_t want;
        logic         fired;
        logic         progress;
        if (!aresetn) begin
            rate_hz         = TICK_RATE_RST;
            debounce        = DEBOUNCE_RST;
            min_win         = MIN_WINDOW_RST;
            max_win         = MAX_WINDOW_RST;
            knots_q16       = KNOTS_RST;
            pend_limit      = PEND_LIMIT_RST;
            tick_now        = '0;
            last_pulse_tick = '0;
            ref_tick        = '0;
            pending         = '0;
            draining        = 1'b0;
            phase_timer     = '0;
            win_count       = '0;
            idle_cycles    <= 0;
        end else begin
            progress = 1'b0;
            if (psel && penable && pwrite && pready) begin
                apply_reg(paddr[4:2], pwdata);
                reg_writes++;
                progress = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                fired = meter_tick(s_tdata[0], predicted);
                if (beat_pinned)
                    awaited_reports.push_back(beat_want);
                else if (fired)
                    awaited_reports.push_back(predicted);
                ticks_taken++;
                progress = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                seen = {m_tdata[23:0], m_tdata[38:24], m_tdata[70:39], m_tuser[0]};
                reports_seen++;
                if (seen.timed_out) timeouts_seen++;
                if (seen.speed_q8 == SPEED_MAX) saturated_seen++;
                if (awaited_reports.size() == 0) begin
                    log_fault("unexpected report", '0, seen);
                end else begin
                    want = awaited_reports.pop_front();
                    if (seen.speed_q8 !== want.speed_q8 || seen.pulse_count !== want.pulse_count ||
                        seen.elapsed_ticks !== want.elapsed_ticks ||
                        seen.timed_out !== want.timed_out)
                        log_fault("report mismatch", want, seen);
                end
                progress = 1'b1;
            end
            idle_cycles <= progress ? 0 : idle_cycles + 1;
        end
    end

    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(16, 160);
        end
        ready_left--;
        case (ready_mode)
            RDY_ALWAYS:  m_tready = 1'b1;
            RDY_COIN:    m_tready = 1'($urandom_range(0, 1));
            RDY_CADENCE: m_tready = (ready_left % 5) >= 2;
            default:     m_tready = $urandom_range(0, 7) != 0;
        endcase
    end

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_tick(input logic pulse, input logic pinned, input wind_report_t want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid    = 1'b1;
        s_tdata     = {7'd0, pulse};
        beat_pinned = pinned;
        beat_want   = want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Hold off until every expected report is in and the block has gone quiet.
    task automatic settle();
        s_tvalid = 1'b0;
        while (awaited_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("tb_anemometer_pulse_rate_meter failed");
        $finish;
    end

    initial begin
        int          phase_ticks;
        int          density;
        int          random_ticks;
        logic [31:0] val;
        bit          after_tick;
        repeat (2) @(negedge aclk);
        aresetn    = 1'b1;
        after_tick = 1'b0;

        for (int i = 0; i < $size(DIRECTED_PLAN); i++) begin
            if (DIRECTED_PLAN[i].kind == ROW_CFG) begin
                if (after_tick) settle();
                reg_write(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].value);
                after_tick = 1'b0;
            end else begin
                send_tick(DIRECTED_PLAN[i].pulse, DIRECTED_PLAN[i].pinned,
                          DIRECTED_PLAN[i].want);
                after_tick = 1'b1;
            end
        end

        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS) begin
            settle();
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0:       val = 1;
                    1:       val = 65535;
                    2:       val = TICK_RATE_RST;
                    default: val = $urandom_range(1, 65535);
                endcase
                reg_write(REG_TICK_RATE, val);
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0, 1:    val = 0;
                    2, 3:    val = $urandom_range(0, 3);
                    4, 5:    val = $urandom_range(0, 12);
                    6:       val = DEBOUNCE_RST;
                    7:       val = 65535;
                    8:       val = $urandom_range(0, 65535);
                    default: val = 1;
                endcase
                reg_write(REG_DEBOUNCE, val);
            end
            if (min_win > 16'd200 || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 11))
                    0, 1:    val = 1;
                    2, 3, 4: val = $urandom_range(1, 6);
                    5, 6:    val = $urandom_range(1, 12);
                    7, 8:    val = $urandom_range(1, 40);
                    11:      val = (min_win > 16'd200) ? 3 : 65535;
                    default: val = $urandom_range(2, 8);
                endcase
                reg_write(REG_MIN_WINDOW, val);
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 7))
                    0:       val = 2;
                    1:       val = 65535;
                    2:       val = min_win;
                    3:       val = $urandom_range(2, 60);
                    default: val = 32'(min_win) + $urandom_range(1, 12);
                endcase
                if (val > 65535) val = 65535;
                reg_write(REG_MAX_WINDOW, val);
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 4))
                    0:       val = 0;
                    1:       val = 24'hFF_FFFF;
                    2:       val = KNOTS_RST;
                    default: val = $urandom_range(0, 24'hFF_FFFF);
                endcase
                reg_write(REG_KNOTS, val);
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 4))
                    0:       val = 1;
                    1:       val = 16383;
                    2, 3:    val = $urandom_range(1, 3);
                    default: val = $urandom_range(1, 16383);
                endcase
                reg_write(REG_PEND_LIMIT, val);
            end

            case ($urandom_range(0, 5))
                0:       density = 0;
                1:       density = 5;
                2, 3:    density = 25;
                4:       density = 60;
                default: density = 100;
            endcase
            phase_ticks = $urandom_range(20, 100);
            repeat (phase_ticks) send_tick($urandom_range(0, 99) < density, 1'b0, '0);
            random_ticks += phase_ticks;
        end
        settle();

        $display("run covered %0d tick beats and %0d register writes", ticks_taken, reg_writes);
        $display("reports checked: %0d, %0d timed out, %0d at full-scale speed",
                 reports_seen, timeouts_seen, saturated_seen);
        if (faults == 0 && awaited_reports.size() == 0)
            $display("tb_anemometer_pulse_rate_meter passed");
        else
            $display("tb_anemometer_pulse_rate_meter failed");
        $finish;
    end

endmodule

// ===== anemometer_pulse_rate_meter.f =====
design/aprm_pkg.sv
design/aprm_win.sv
design/aprm_arith.sv
design/anemometer_pulse_rate_meter.sv
tb/sv/tb_anemometer_pulse_rate_meter.sv
